// ===== hw/rtl/rlmaf_pkg.sv =====
// shared constants, types and controller codes for the slew limit, median and average filter
package rlmaf_pkg;

  localparam int AVG_DEPTH    = 16;
  localparam int MED_DEPTH    = 8;
  localparam int SAMPLE_WIDTH = 16;

  localparam int AVG_IDX_W = (AVG_DEPTH > 1) ? $clog2(AVG_DEPTH) : 1;
  localparam int MED_IDX_W = (MED_DEPTH > 1) ? $clog2(MED_DEPTH) : 1;
  localparam int AVG_LEN_W = $clog2(AVG_DEPTH + 1);
  localparam int MED_LEN_W = $clog2(MED_DEPTH + 1);
  localparam int SUM_W     = SAMPLE_WIDTH + $clog2(AVG_DEPTH);
  localparam int MAG_W     = SUM_W;
  localparam int DIV_CNT_W = $clog2(MAG_W);

  // register fields
  localparam int AVG_LEN_FW = 5;
  localparam int MED_LEN_FW = 4;
  localparam int STEP_FW    = 15;
  localparam int TRUST_FW   = 16;

  localparam logic [AVG_LEN_FW-1:0]      AVG_LEN_RST    = 5'd10;
  localparam logic [MED_LEN_FW-1:0]      MED_LEN_RST    = 4'd5;
  localparam logic [STEP_FW-1:0]         STEP_RST       = 15'd8;
  localparam logic signed [TRUST_FW-1:0] TRUST_LOW_RST  = 16'sd0;
  localparam logic signed [TRUST_FW-1:0] TRUST_HIGH_RST = 16'sd3680;

  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = CFG_ADDR_W - 2;

  localparam logic [CFG_IDX_W-1:0] REG_AVG_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MED_LEN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_LIMIT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TRUST_LOW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TRUST_HIGH = 3'd4;

  typedef logic signed [SAMPLE_WIDTH-1:0] val_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MEDIAN,
    ST_SUM,
    ST_START,
    ST_DIV,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic [AVG_LEN_W-1:0]      avg_len;
    logic [MED_LEN_W-1:0]      med_len;
    logic [STEP_FW-1:0]        step_limit;
    logic signed [TRUST_FW-1:0] trust_low;
    logic signed [TRUST_FW-1:0] trust_high;
    logic                      clear;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic med_next;
    logic avg_write;
    logic sum_step;
    logic div_start;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic med_found;
    logic sum_last;
    logic div_done;
  } status_t;

endpackage

// ===== hw/rtl/rlmaf_regs.sv =====
// configuration registers behind the apb-style port
module rlmaf_regs (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rlmaf_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [rlmaf_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [rlmaf_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                                pready,
  output rlmaf_pkg::cfg_t                     cfg
);
  import rlmaf_pkg::*;

  logic [AVG_LEN_FW-1:0]      avg_len;
  logic [MED_LEN_FW-1:0]      med_len;
  logic [STEP_FW-1:0]         step_limit;
  logic signed [TRUST_FW-1:0] trust_low;
  logic signed [TRUST_FW-1:0] trust_high;
  logic [CFG_IDX_W-1:0]       idx;
  logic                       wr;

  assign idx    = paddr[CFG_ADDR_W-1:2];
  assign wr     = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      avg_len    <= AVG_LEN_RST;
      med_len    <= MED_LEN_RST;
      step_limit <= STEP_RST;
      trust_low  <= TRUST_LOW_RST;
      trust_high <= TRUST_HIGH_RST;
    end else if (wr) begin
      case (idx)
        REG_AVG_LEN:    avg_len    <= pwdata[AVG_LEN_FW-1:0];
        REG_MED_LEN:    med_len    <= pwdata[MED_LEN_FW-1:0];
        REG_STEP_LIMIT: step_limit <= pwdata[STEP_FW-1:0];
        REG_TRUST_LOW:  trust_low  <= pwdata[TRUST_FW-1:0];
        REG_TRUST_HIGH: trust_high <= pwdata[TRUST_FW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_AVG_LEN:    prdata = CFG_DATA_W'(avg_len);
      REG_MED_LEN:    prdata = CFG_DATA_W'(med_len);
      REG_STEP_LIMIT: prdata = CFG_DATA_W'(step_limit);
      REG_TRUST_LOW:  prdata = CFG_DATA_W'($unsigned(trust_low));
      REG_TRUST_HIGH: prdata = CFG_DATA_W'($unsigned(trust_high));
      default:        prdata = '0;
    endcase
  end

  // zero or oversized lengths fall back to the full ring
  always_comb begin
    cfg.avg_len    = (avg_len == '0 || int'(avg_len) > AVG_DEPTH) ?
                     AVG_LEN_W'(AVG_DEPTH) : AVG_LEN_W'(avg_len);
    cfg.med_len    = (med_len == '0 || int'(med_len) > MED_DEPTH) ?
                     MED_LEN_W'(MED_DEPTH) : MED_LEN_W'(med_len);
    cfg.step_limit = step_limit;
    cfg.trust_low  = trust_low;
    cfg.trust_high = trust_high;
    cfg.clear      = wr && (idx == REG_AVG_LEN || idx == REG_MED_LEN);
  end

endmodule

// ===== hw/rtl/rlmaf_div.sv =====
// bit-serial signed divider, truncating toward zero, one quotient bit a cycle
module rlmaf_div (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [rlmaf_pkg::SUM_W-1:0]  dividend,
  input  logic [rlmaf_pkg::AVG_LEN_W-1:0]     divisor,
  output logic                                done,
  output rlmaf_pkg::val_t                     quotient
);
  import rlmaf_pkg::*;

  logic                 busy;
  logic                 neg;
  logic [DIV_CNT_W-1:0] cnt;
  logic [MAG_W-1:0]     mag;
  logic [AVG_LEN_W-1:0] rem;
  logic [AVG_LEN_W:0]   rem_sh;
  logic                 fits;
  logic [MAG_W-1:0]     q_signed;

  assign rem_sh   = {rem, mag[MAG_W-1]};
  assign fits     = rem_sh >= {1'b0, divisor};
  assign q_signed = neg ? (-mag) : mag;
  assign quotient = q_signed[SAMPLE_WIDTH-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == DIV_CNT_W'(MAG_W - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  // mag holds the remaining dividend bits and collects the quotient from the bottom
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[SUM_W-1];
      mag <= dividend[SUM_W-1] ? $unsigned(-dividend) : $unsigned(dividend);
      rem <= '0;
      cnt <= '0;
    end else if (busy) begin
      rem <= fits ? AVG_LEN_W'(rem_sh - {1'b0, divisor}) : rem_sh[AVG_LEN_W-1:0];
      mag <= {mag[MAG_W-2:0], fits};
      cnt <= cnt + 1'b1;
    end
  end

endmodule

// ===== hw/rtl/rlmaf_ctrl.sv =====
// sequencer: accepts a request, steps median search, ring sum and divide, loads the result
module rlmaf_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  input  rlmaf_pkg::status_t   status,
  output rlmaf_pkg::cmd_t      cmd
);
  import rlmaf_pkg::*;

  state_t state, state_next;

  assign in_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MEDIAN;
        end
      end
      ST_MEDIAN: begin
        if (status.med_found) begin
          cmd.avg_write = 1'b1;
          state_next    = ST_SUM;
        end else begin
          cmd.med_next = 1'b1;
        end
      end
      ST_SUM: begin
        cmd.sum_step = 1'b1;
        if (status.sum_last) state_next = ST_START;
      end
      ST_START: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_done) state_next = ST_OUT;
      end
      ST_OUT: begin
        // wait until the previous result has left the output register
        if (!out_valid || !out_stall) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== hw/rtl/rlmaf_datapath.sv =====
// slew limiter, median ring with rank search, average ring with serial sum, output register
module rlmaf_datapath (
  input  logic                 clk,
  input  logic                 rst,
  input  rlmaf_pkg::cfg_t      cfg,
  input  rlmaf_pkg::cmd_t      cmd,
  output rlmaf_pkg::status_t   status,
  input  rlmaf_pkg::val_t      sample,
  output rlmaf_pkg::val_t      filtered,
  output rlmaf_pkg::val_t      limited,
  output logic                 primed
);
  import rlmaf_pkg::*;

  logic                    primed_flag;
  val_t                    prev_val;
  val_t                    med_ring [MED_DEPTH];
  logic [MED_IDX_W-1:0]    med_pos;
  val_t                    avg_ring [AVG_DEPTH];
  logic [AVG_IDX_W-1:0]    avg_pos;

  logic [MED_IDX_W-1:0]    cand_idx;
  logic [AVG_IDX_W-1:0]    sum_idx;
  logic signed [SUM_W-1:0] acc;
  val_t                    lim_r;

  logic                    prime;
  logic signed [SAMPLE_WIDTH+1:0] diff;
  logic signed [SAMPLE_WIDTH+1:0] step_x;
  val_t                    lim;
  logic [MED_IDX_W-1:0]    wpos;
  logic                    wpos_last;
  logic                    avg_pos_last;

  val_t                    cand;
  logic [MED_LEN_W-1:0]    less_cnt;
  logic [MED_LEN_W-1:0]    leq_cnt;
  logic [MED_LEN_W-1:0]    mid;

  logic                    div_done;
  val_t                    quotient;

  // slew limiter
  always_comb begin
    prime  = !primed_flag && (sample > cfg.trust_low) && (sample < cfg.trust_high);
    diff   = (SAMPLE_WIDTH+2)'(sample) - (SAMPLE_WIDTH+2)'(prev_val);
    step_x = (SAMPLE_WIDTH+2)'(cfg.step_limit);
    if (prime) begin
      lim = sample;
    end else if (!primed_flag) begin
      lim = prev_val;
    end else if (diff > step_x) begin
      lim = val_t'((SAMPLE_WIDTH+2)'(prev_val) + step_x);
    end else if (diff < -step_x) begin
      lim = val_t'((SAMPLE_WIDTH+2)'(prev_val) - step_x);
    end else begin
      lim = sample;
    end
    wpos         = prime ? '0 : med_pos;
    wpos_last    = (MED_LEN_W'(wpos) == cfg.med_len - MED_LEN_W'(1));
    avg_pos_last = (AVG_LEN_W'(avg_pos) == cfg.avg_len - AVG_LEN_W'(1));
  end

  // rank of the current candidate against every live median entry
  always_comb begin
    cand     = med_ring[cand_idx];
    less_cnt = '0;
    leq_cnt  = '0;
    for (int j = 0; j < MED_DEPTH; j++) begin
      if (MED_LEN_W'(j) < cfg.med_len) begin
        if (med_ring[j] < cand)  less_cnt = less_cnt + MED_LEN_W'(1);
        if (med_ring[j] <= cand) leq_cnt  = leq_cnt + MED_LEN_W'(1);
      end
    end
    mid = cfg.med_len >> 1;
    status.med_found = (less_cnt <= mid) && (mid < leq_cnt);
    status.sum_last  = (AVG_LEN_W'(sum_idx) == cfg.avg_len - AVG_LEN_W'(1));
    status.div_done  = div_done;
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst || cfg.clear) begin
      primed_flag <= 1'b0;
      prev_val    <= '0;
      med_pos     <= '0;
      avg_pos     <= '0;
      for (int i = 0; i < MED_DEPTH; i++) med_ring[i] <= '0;
      for (int i = 0; i < AVG_DEPTH; i++) avg_ring[i] <= '0;
    end else begin
      if (cmd.load) begin
        if (prime) primed_flag <= 1'b1;
        if (prime || primed_flag) prev_val <= lim;
        // a priming sample fills the live part of both rings
        for (int i = 0; i < MED_DEPTH; i++) begin
          if ((prime && MED_LEN_W'(i) < cfg.med_len) || MED_IDX_W'(i) == wpos) begin
            med_ring[i] <= lim;
          end
        end
        med_pos <= wpos_last ? '0 : wpos + 1'b1;
        if (prime) begin
          for (int i = 0; i < AVG_DEPTH; i++) begin
            if (AVG_LEN_W'(i) < cfg.avg_len) avg_ring[i] <= sample;
          end
          avg_pos <= '0;
        end
      end
      if (cmd.avg_write) begin
        avg_ring[avg_pos] <= cand;
        avg_pos <= avg_pos_last ? '0 : avg_pos + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      lim_r    <= lim;
      cand_idx <= '0;
    end else if (cmd.med_next) begin
      cand_idx <= cand_idx + 1'b1;
    end
    if (cmd.avg_write) begin
      acc     <= '0;
      sum_idx <= '0;
    end else if (cmd.sum_step) begin
      acc     <= acc + SUM_W'(avg_ring[sum_idx]);
      sum_idx <= sum_idx + 1'b1;
    end
    if (cmd.out_load) begin
      filtered <= quotient;
      limited  <= lim_r;
      primed   <= primed_flag;
    end
  end

  rlmaf_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (acc),
    .divisor  (cfg.avg_len),
    .done     (div_done),
    .quotient (quotient)
  );

endmodule

// ===== hw/rtl/rate_limit_median_average_filter_core.sv =====
// top level of the slew limit, median and moving average temperature filter
//
// Input channel: sample with in_valid / in_stall; a request is taken at a rising edge
// with in_valid high and in_stall low. Output channel: filtered, limited and primed with
// out_valid / out_stall, one result for every request.
// Configuration goes through the apb-style port (registers at byte address 4*i); the user
// must write it only while the block is idle, which the block itself does not enforce.
// Writing either length clears the filter state. Each request runs through one sequencer:
// a load step (slew limit and ring writes), a rank search over the median ring, a walk
// over the average ring, a divider start and the bit-serial divide, then a load of the
// output register. The next request is taken in the cycle after that load.
// The result waits in the output register while out_stall is high; the next request is
// accepted and processed meanwhile and holds in its final step until the register frees.
// After rst the registers hold their reset values, both rings are zero, the filter is
// unprimed and no result is pending.
module rate_limit_median_average_filter_core (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rlmaf_pkg::CFG_ADDR_W-1:0]  paddr,
  input  logic [rlmaf_pkg::CFG_DATA_W-1:0]  pwdata,
  output logic [rlmaf_pkg::CFG_DATA_W-1:0]  prdata,
  output logic                              pready,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  rlmaf_pkg::val_t                   sample,
  output logic                              out_valid,
  input  logic                              out_stall,
  output rlmaf_pkg::val_t                   filtered,
  output rlmaf_pkg::val_t                   limited,
  output logic                              primed
);
  import rlmaf_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  rlmaf_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  rlmaf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  rlmaf_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .status   (status),
    .sample   (sample),
    .filtered (filtered),
    .limited  (limited),
    .primed   (primed)
  );

endmodule
